// File: hw/rtl/stepper_trapezoid_ramp_core_defines.svh
// Assertion macros shared by the stepper ramp RTL.
`ifndef STEPPER_TRAPEZOID_RAMP_CORE_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STRAMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stramp: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define STRAMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stramp: next-cycle check failed");

`endif

// File: hw/rtl/stramp_pkg.sv
// Package with types, constants and helpers for the stepper ramp block.
package stramp_pkg;

    // Configuration port sizing and register indexes.
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RELOAD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RELOAD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_DISTANCE = 2'd2;

    // Register reset values.
    localparam logic [23:0] MIN_RELOAD_RST     = 24'd1000;
    localparam logic [23:0] MAX_RELOAD_RST     = 24'd10000;
    localparam logic [15:0] DECEL_DISTANCE_RST = 16'd100;

    // Default ramp increment after reset.
    localparam int unsigned RELOAD_STEP_RESET_DEF = 16;

    // Request codes.
    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_SET_TARGET = 2'd1;
    localparam logic [1:0] REQ_GO_HOME    = 2'd2;

    // Ramp constants.
    localparam logic [17:0] MIN_INCREMENT   = 18'd2;
    localparam logic [22:0] HOME_MIN_FLOOR  = 23'd20;
    localparam logic [16:0] TARGET_DEADBAND = 17'd10;
    localparam logic signed [15:0] HOME_TARGET = -16'sd100;
    localparam logic [31:0] IDLE_AT_ZERO    = 32'hFFFF_FFFF;

    // Reciprocal of five scaled by 2^23, rounded up; exact for 20-bit operands.
    localparam logic [20:0] RECIP5 = 21'd1677722;
    localparam int RECIP5_SHIFT    = 23;

    typedef enum logic [1:0] {
        MS_STOPPED,
        MS_ACCEL,
        MS_CRUISE,
        MS_DECEL
    } motion_state_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [15:0]  target_steps;
    } req_t;

    typedef struct packed {
        logic [31:0]         reload;
        logic                step_pulse;
        logic                dir_high;
        logic                enable_pulse;
        logic signed [15:0]  position;
    } rsp_t;

    typedef struct packed {
        logic [23:0] min_reload;
        logic [23:0] max_reload;
        logic [15:0] decel_distance;
    } cfg_t;

    // Divide a 24-bit value by 80: shift out the factor sixteen, then
    // multiply by the reciprocal of five.
    function automatic logic [17:0] div80(input logic [23:0] x);
        logic [19:0] y;
        logic [40:0] prod;
        y    = x[23:4];
        prod = 41'(y) * 41'(RECIP5);
        return prod[RECIP5_SHIFT+17:RECIP5_SHIFT];
    endfunction

endpackage

// File: hw/rtl/stramp_stream_if.sv
// Valid/ready stream interface carrying one word per handshake.
interface stramp_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/stepper_trapezoid_ramp_core.sv
// Top level of the trapezoidal stepper ramp generator.
//
//   channel  dir  word   contents
//   cmd      in   req_t  req_type, target_steps
//   rsp      out  rsp_t  reload, step_pulse, dir_high, enable_pulse, position
//   wr_*     in   -      register write: wr_en, wr_index, wr_data
//
// One word per cycle is sustained while rsp.ready is high; each word passes from
// acceptance through the input register and then the result register.
// The ramp update is a single combinational pass gated by a free result register.
// Reset clears the ramp state, the registers go to their defaults; no clearing pass.
// A stalled result holds its register, and the input register takes one more
// word behind it before cmd.ready drops.
module stepper_trapezoid_ramp_core #(
    parameter int unsigned RELOAD_STEP_RESET = stramp_pkg::RELOAD_STEP_RESET_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    stramp_stream_if.sink                     cmd,
    stramp_stream_if.source                   rsp,
    input  logic                              wr_en,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [stramp_pkg::CFG_DATA_W-1:0] wr_data
);
    import stramp_pkg::*;

    `include "stepper_trapezoid_ramp_core_defines.svh"

    logic  in_valid_reg, in_valid_next;
    req_t  in_data_reg;
    logic  out_valid_reg, out_valid_next;
    rsp_t  out_data_reg;
    logic  fire;
    logic  cmd_take;
    cfg_t  cfg;
    rsp_t  result;

    stramp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    stramp_ramp_engine #(
        .RELOAD_STEP_RESET (RELOAD_STEP_RESET)
    ) u_ramp_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .req     (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // A held word is processed when the result register is free or being emptied.
    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || fire;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next  = cmd_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_data_reg <= cmd.data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // A processed word always lands in the result register.
    `STRAMP_ASSERT_NEXT(a_fire_fills_out, clk, rst_n, fire, out_valid_reg)
    // A held word that is not processed is kept.
    `STRAMP_ASSERT_NEXT(a_in_kept, clk, rst_n, in_valid_reg && !fire, in_valid_reg)
    // Back-pressure on cmd only while a word waits in the input register.
    `STRAMP_ASSERT_NOW(a_ready_low_full, clk, rst_n, !cmd.ready, in_valid_reg && out_valid_reg)
endmodule

// File: hw/rtl/stramp_cfg_regs.sv
// Configuration register file of the stepper ramp block.
module stramp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [stramp_pkg::CFG_DATA_W-1:0] wr_data,
    output stramp_pkg::cfg_t                  cfg
);
    import stramp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register; other indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MIN_RELOAD:     cfg_next.min_reload     = wr_data;
                CFG_MAX_RELOAD:     cfg_next.max_reload     = wr_data;
                CFG_DECEL_DISTANCE: cfg_next.decel_distance = wr_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_reload     <= MIN_RELOAD_RST;
            cfg_reg.max_reload     <= MAX_RELOAD_RST;
            cfg_reg.decel_distance <= DECEL_DISTANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: hw/rtl/stramp_ramp_engine.sv
// Ramp state and the combinational update for one request word.
module stramp_ramp_engine #(
    parameter int unsigned RELOAD_STEP_RESET = stramp_pkg::RELOAD_STEP_RESET_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  stramp_pkg::req_t  req,
    input  stramp_pkg::cfg_t  cfg,
    output stramp_pkg::rsp_t  result
);
    import stramp_pkg::*;

    motion_state_t      state_reg, state_next;
    logic               dir_pos_reg, dir_pos_next;
    logic signed [15:0] pos_reg, pos_next;
    logic signed [15:0] tgt_reg, tgt_next;
    logic               homing_reg, homing_next;
    logic [31:0]        reload_reg, reload_next;
    logic [23:0]        amr_reg, amr_next;
    logic [23:0]        inc_reg, inc_next;

    logic               pulse, enable, pos_clear;
    logic               pos_ne_tgt, reverse, far_from_tgt, capped;
    logic signed [16:0] delta;
    logic [16:0]        abs_delta;
    logic [31:0]        accel_reload, decel_reload;
    logic [32:0]        decel_sum;
    logic [23:0]        reload_span;
    logic [17:0]        span_div;
    logic [23:0]        inc_set;
    logic signed [16:0] tgt_dist;
    logic [16:0]        abs_dist;
    logic               tgt_ignored;
    logic [22:0]        half_min;
    logic [23:0]        amr_home;

    // Shared comparisons against the current position and target.
    always_comb
    begin
        pos_ne_tgt   = (pos_reg != tgt_reg);
        reverse      = (state_reg != MS_STOPPED) &&
                       (dir_pos_reg ? (tgt_reg < pos_reg) : (tgt_reg > pos_reg));
        delta        = 17'(tgt_reg) - 17'(pos_reg);
        abs_delta    = delta[16] ? 17'(-delta) : 17'(delta);
        far_from_tgt = abs_delta > {1'b0, cfg.decel_distance};
    end

    // Saturating ramp arithmetic for acceleration and deceleration.
    always_comb
    begin
        accel_reload = (reload_reg > {8'd0, inc_reg}) ? (reload_reg - {8'd0, inc_reg}) : '0;
        decel_sum    = {1'b0, reload_reg} + {9'd0, inc_reg};
        decel_reload = decel_sum[32] ? IDLE_AT_ZERO : decel_sum[31:0];
        capped       = decel_reload > {8'd0, cfg.max_reload};
    end

    // New ramp increment and deadband check for a set-target request, and the homing speed floor for go-home.
    always_comb
    begin
        reload_span = (cfg.max_reload >= cfg.min_reload) ?
                      (cfg.max_reload - cfg.min_reload) : '0;
        span_div    = div80(reload_span);
        inc_set     = (span_div < MIN_INCREMENT) ? {6'd0, MIN_INCREMENT} : {6'd0, span_div};
        tgt_dist    = 17'(tgt_reg) - 17'(req.target_steps);
        abs_dist    = tgt_dist[16] ? 17'(-tgt_dist) : 17'(tgt_dist);
        tgt_ignored = (abs_dist != '0) && (abs_dist < TARGET_DEADBAND);
        half_min    = cfg.min_reload[23:1];
        amr_home    = (half_min < HOME_MIN_FLOOR) ? {1'b0, HOME_MIN_FLOOR} : {1'b0, half_min};
    end

    // Next-state logic for every request kind.
    always_comb
    begin
        state_next   = state_reg;
        dir_pos_next = dir_pos_reg;
        tgt_next     = tgt_reg;
        homing_next  = homing_reg;
        reload_next  = reload_reg;
        amr_next     = amr_reg;
        inc_next     = inc_reg;
        pulse        = 1'b0;
        enable       = 1'b0;
        pos_clear    = 1'b0;

        unique case (req.req_type)
            REQ_TICK:
            begin
                // A reversal overrides the current phase with deceleration.
                state_next = reverse ? MS_DECEL : state_reg;
                unique case (state_next)
                    MS_STOPPED:
                    begin
                        if (pos_ne_tgt)
                        begin
                            enable       = 1'b1;
                            dir_pos_next = (pos_reg < tgt_reg);
                            state_next   = MS_ACCEL;
                            reload_next  = {8'd0, cfg.max_reload};
                            pulse        = 1'b1;
                        end
                        else
                        begin
                            reload_next = (pos_reg == '0) ? IDLE_AT_ZERO : '0;
                        end
                    end
                    MS_ACCEL:
                    begin
                        reload_next = accel_reload;
                        if (accel_reload < {8'd0, amr_reg})
                        begin
                            reload_next = {8'd0, amr_reg};
                            state_next  = MS_CRUISE;
                        end
                        if (pos_ne_tgt)
                        begin
                            pulse = 1'b1;
                        end
                        else if (accel_reload >= {8'd0, amr_reg})
                        begin
                            state_next = MS_STOPPED;
                        end
                    end
                    MS_CRUISE:
                    begin
                        if (far_from_tgt)
                        begin
                            pulse = 1'b1;
                        end
                        else
                        begin
                            state_next = MS_DECEL;
                        end
                    end
                    MS_DECEL:
                    begin
                        reload_next = capped ? {8'd0, cfg.max_reload} : decel_reload;
                        if (capped && reverse)
                        begin
                            // Back at start speed after a reversal: flip and stop.
                            dir_pos_next = !dir_pos_reg;
                            state_next   = MS_STOPPED;
                        end
                        else if (pos_ne_tgt)
                        begin
                            pulse = 1'b1;
                        end
                        else
                        begin
                            // Arrived; a negative target marks the home position.
                            reload_next = '0;
                            state_next  = MS_STOPPED;
                            if (tgt_reg < 0)
                            begin
                                tgt_next  = '0;
                                pos_clear = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = MS_STOPPED;
                    end
                endcase
            end
            REQ_SET_TARGET:
            begin
                amr_next = cfg.min_reload;
                inc_next = inc_set;
                if (!tgt_ignored)
                begin
                    homing_next = 1'b0;
                    tgt_next    = req.target_steps;
                end
            end
            REQ_GO_HOME:
            begin
                if (!homing_reg && (tgt_reg > 0))
                begin
                    homing_next = 1'b1;
                    tgt_next    = HOME_TARGET;
                end
                amr_next = amr_home;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // Position update: one step in the new direction, or cleared on homing.
    always_comb
    begin
        if (pulse)
        begin
            pos_next = dir_pos_next ? (pos_reg + 16'sd1) : (pos_reg - 16'sd1);
        end
        else if (pos_clear)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // Result word built from the updated state.
    always_comb
    begin
        result.reload       = reload_next;
        result.step_pulse   = pulse;
        result.dir_high     = dir_pos_next;
        result.enable_pulse = enable;
        result.position     = pos_next;
    end

    // State registers advance once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= MS_STOPPED;
            dir_pos_reg <= 1'b1;
            pos_reg     <= '0;
            tgt_reg     <= '0;
            homing_reg  <= 1'b0;
            reload_reg  <= '0;
            amr_reg     <= MIN_RELOAD_RST;
            inc_reg     <= 24'(RELOAD_STEP_RESET);
        end
        else if (step_en)
        begin
            state_reg   <= state_next;
            dir_pos_reg <= dir_pos_next;
            pos_reg     <= pos_next;
            tgt_reg     <= tgt_next;
            homing_reg  <= homing_next;
            reload_reg  <= reload_next;
            amr_reg     <= amr_next;
            inc_reg     <= inc_next;
        end
    end
endmodule

// File: tb/stepper_trapezoid_ramp_checker.sv
// Checker for the stepper ramp core: tracks the ramp state and compares every result word.
module stepper_trapezoid_ramp_checker #(
    parameter int unsigned RELOAD_STEP_RESET = stramp_pkg::RELOAD_STEP_RESET_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_ready,
    input  stramp_pkg::req_t                  cmd_data,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  stramp_pkg::rsp_t                  rsp_data,
    input  logic                              wr_en,
    input  logic [stramp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [stramp_pkg::CFG_DATA_W-1:0] wr_data,
    output int                                errors,
    output int                                pending,
    output int                                words_checked,
    output int                                steps_seen,
    output int                                homing_arrivals
);
    timeunit 1ns;
    timeprecision 1ps;

    import stramp_pkg::*;

    localparam int RAMP_DIVISOR = 80;

    // Register copies as the block sees them.
    logic [23:0]        min_reload_q;
    logic [23:0]        max_reload_q;
    logic [15:0]        decel_dist_q;

    // Ramp state mirrored from the block.
    motion_state_t      motion_q;
    logic               fwd_q;
    logic signed [15:0] pos_q;
    logic signed [15:0] target_q;
    logic               homing_q;
    logic [31:0]        reload_q;
    logic [23:0]        fast_reload_q;
    logic [23:0]        ramp_incr_q;

    // Result words still owed by the block, oldest first.
    rsp_t               owed_words[$];

    // Advance the ramp by one command word and return the result word it gives.
    function automatic rsp_t advance_ramp(input req_t w);
        rsp_t               word;
        logic               reversing;
        logic               stepping;
        logic               flipped;
        logic [32:0]        sum;
        logic [23:0]        span;
        int                 delta;
        int                 tgt_gap;
        word      = '0;
        reversing = 1'b0;
        stepping  = 1'b0;
        flipped   = 1'b0;
        case (w.req_type)
            REQ_TICK:
            begin
                // A target behind the direction of travel forces a deceleration.
                if (motion_q != MS_STOPPED)
                begin
                    reversing = fwd_q ? (target_q < pos_q) : (target_q > pos_q);
                    if (reversing)
                        motion_q = MS_DECEL;
                end
                case (motion_q)
                    MS_STOPPED:
                    begin
                        if (pos_q != target_q)
                        begin
                            word.enable_pulse = 1'b1;
                            fwd_q             = pos_q < target_q;
                            motion_q          = MS_ACCEL;
                            reload_q          = 32'(max_reload_q);
                            stepping          = 1'b1;
                        end
                        else
                        begin
                            reload_q = (pos_q == 16'sd0) ? IDLE_AT_ZERO : 32'd0;
                        end
                    end
                    MS_ACCEL:
                    begin
                        // The subtraction stops at zero rather than wrapping.
                        reload_q = (reload_q > 32'(ramp_incr_q)) ?
                                   reload_q - 32'(ramp_incr_q) : 32'd0;
                        if (reload_q < 32'(fast_reload_q))
                        begin
                            reload_q = 32'(fast_reload_q);
                            motion_q = MS_CRUISE;
                        end
                        if (target_q != pos_q)
                            stepping = 1'b1;
                        else if (motion_q == MS_ACCEL)
                            motion_q = MS_STOPPED;
                    end
                    MS_CRUISE:
                    begin
                        delta = int'(target_q) - int'(pos_q);
                        if (delta < -int'(decel_dist_q) || delta > int'(decel_dist_q))
                            stepping = 1'b1;
                        else
                            motion_q = MS_DECEL;
                    end
                    default:
                    begin
                        sum      = 33'(reload_q) + 33'(ramp_incr_q);
                        reload_q = sum[32] ? '1 : sum[31:0];
                        if (reload_q > 32'(max_reload_q))
                        begin
                            reload_q = 32'(max_reload_q);
                            // Slow enough to turn round: flip and stop.
                            if (reversing)
                            begin
                                fwd_q    = !fwd_q;
                                motion_q = MS_STOPPED;
                                flipped  = 1'b1;
                            end
                        end
                        if (!flipped)
                        begin
                            if (pos_q != target_q)
                            begin
                                stepping = 1'b1;
                            end
                            else
                            begin
                                reload_q = 32'd0;
                                motion_q = MS_STOPPED;
                                // Arrival below zero marks home: both become zero.
                                if (target_q < 16'sd0)
                                begin
                                    target_q = '0;
                                    pos_q    = '0;
                                    homing_arrivals++;
                                end
                            end
                        end
                    end
                endcase
            end
            REQ_SET_TARGET:
            begin
                // The ramp is re-derived even when the target falls in the deadband.
                span          = (max_reload_q >= min_reload_q) ?
                                max_reload_q - min_reload_q : '0;
                fast_reload_q = min_reload_q;
                ramp_incr_q   = span / 24'(RAMP_DIVISOR);
                if (ramp_incr_q < 24'(MIN_INCREMENT))
                    ramp_incr_q = 24'(MIN_INCREMENT);
                tgt_gap = int'(target_q) - int'(w.target_steps);
                if (tgt_gap < 0)
                    tgt_gap = -tgt_gap;
                if (tgt_gap == 0 || tgt_gap >= int'(TARGET_DEADBAND))
                begin
                    homing_q = 1'b0;
                    target_q = w.target_steps;
                end
            end
            REQ_GO_HOME:
            begin
                if (!homing_q && target_q > 16'sd0)
                begin
                    homing_q = 1'b1;
                    target_q = HOME_TARGET;
                end
                fast_reload_q = {1'b0, min_reload_q[23:1]};
                if (fast_reload_q < 24'(HOME_MIN_FLOOR))
                    fast_reload_q = 24'(HOME_MIN_FLOOR);
            end
            default:
            begin
            end
        endcase
        if (stepping)
        begin
            word.step_pulse = 1'b1;
            pos_q           = fwd_q ? pos_q + 16'sd1 : pos_q - 16'sd1;
            steps_seen++;
        end
        word.reload   = reload_q;
        word.dir_high = fwd_q;
        word.position = pos_q;
        return word;
    endfunction

    function automatic int field_differs(input string name, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
        if (want === got)
            return 0;
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    // Compare returning words, then predict for the accepted command word.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            min_reload_q    = MIN_RELOAD_RST;
            max_reload_q    = MAX_RELOAD_RST;
            decel_dist_q    = DECEL_DISTANCE_RST;
            motion_q        = MS_STOPPED;
            fwd_q           = 1'b1;
            pos_q           = '0;
            target_q        = '0;
            homing_q        = 1'b0;
            reload_q        = '0;
            fast_reload_q   = MIN_RELOAD_RST;
            ramp_incr_q     = 24'(RELOAD_STEP_RESET);
            owed_words.delete();
            errors          = 0;
            words_checked   = 0;
            steps_seen      = 0;
            homing_arrivals = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("result word with nothing expected: reload %0d, position %0d",
                           rsp_data.reload, rsp_data.position);
                    errors++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    words_checked++;
                    errors += field_differs("reload", want.reload, rsp_data.reload);
                    errors += field_differs("step_pulse", want.step_pulse, rsp_data.step_pulse);
                    errors += field_differs("dir_high", want.dir_high, rsp_data.dir_high);
                    errors += field_differs("enable_pulse", want.enable_pulse,
                                            rsp_data.enable_pulse);
                    errors += field_differs("position", want.position, rsp_data.position);
                end
            end
            if (cmd_valid && cmd_ready)
                owed_words.push_back(advance_ramp(cmd_data));
            if (wr_en)
            begin
                case (wr_index)
                    CFG_MIN_RELOAD:     min_reload_q = wr_data;
                    CFG_MAX_RELOAD:     max_reload_q = wr_data;
                    CFG_DECEL_DISTANCE: decel_dist_q = wr_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = owed_words.size();
    end

endmodule

// File: tb/tb_stepper_trapezoid_ramp_core.sv
// Testbench top for the stepper ramp core: clock, reset, stimulus and the verdict.
module tb_stepper_trapezoid_ramp_core;
    timeunit 1ns;
    timeprecision 1ps;

    import stramp_pkg::*;

    localparam int         CLK_HALF        = 5;
    localparam logic [1:0] REQ_IDLE        = 2'd3;
    localparam int         PHASES          = 6;
    localparam int         WORDS_PER_PHASE = 90;
    localparam int         FINAL_TICKS     = 100;
    localparam int         LONG_HOLD       = 300;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         CYCLE_LIMIT     = 600000;
    localparam logic [23:0] FULL24         = 24'hFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    stramp_stream_if #(.data_t(req_t)) cmd_if ();
    stramp_stream_if #(.data_t(rsp_t)) rsp_if ();

    int errors;
    int pending;
    int words_checked;
    int steps_seen;
    int homing_arrivals;

    // Idling controls, set only at a rising edge while no word is on offer; the result side clears hold_rsp.
    logic src_idles;
    logic snk_idles;
    logic hold_rsp;

    int n_ticks;
    int n_targets;
    int n_homes;
    int n_idle;
    int cycles;
    logic signed [15:0] recent_aim;

    stepper_trapezoid_ramp_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_if),
        .rsp      (rsp_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    stepper_trapezoid_ramp_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_if.valid),
        .cmd_ready       (cmd_if.ready),
        .cmd_data        (cmd_if.data),
        .rsp_valid       (rsp_if.valid),
        .rsp_ready       (rsp_if.ready),
        .rsp_data        (rsp_if.data),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .errors          (errors),
        .pending         (pending),
        .words_checked   (words_checked),
        .steps_seen      (steps_seen),
        .homing_arrivals (homing_arrivals)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else if (snk_idles && $urandom_range(0, 3) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (pick_gap() - 1) @(negedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Offer one command word and hold it until accepted; called at a falling edge.
    task automatic push_word(input logic [1:0] kind, input logic [15:0] steps);
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= {kind, steps};
        do
            @(posedge clk);
        while (!cmd_if.ready);
        @(negedge clk);
        case (kind)
            REQ_TICK:       n_ticks++;
            REQ_SET_TARGET: n_targets++;
            REQ_GO_HOME:    n_homes++;
            default:        n_idle++;
        endcase
        if (src_idles && $urandom_range(0, 2) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    // Stop offering, let every owed word come back, then pick the idling for the next part.
    task automatic settle(input logic src_mode, input logic snk_mode);
        cmd_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        @(posedge clk);
        src_idles = src_mode;
        snk_idles = snk_mode;
        @(negedge clk);
    endtask

    // Write all three registers on consecutive cycles while the block is idle.
    task automatic load_settings(input logic [23:0] fast, input logic [23:0] slow,
                                 input logic [23:0] brake);
        wr_en    <= 1'b1;
        wr_index <= CFG_MIN_RELOAD;
        wr_data  <= fast;
        @(negedge clk);
        wr_index <= CFG_MAX_RELOAD;
        wr_data  <= slow;
        @(negedge clk);
        wr_index <= CFG_DECEL_DISTANCE;
        wr_data  <= brake;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // One random move: a target, home or idle word followed by a run of ticks.
    task automatic run_move();
        int                 pick;
        int                 span;
        logic signed [15:0] aim;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            aim = 16'(int'($urandom_range(0, 200)) - 100);
            push_word(REQ_SET_TARGET, aim);
            recent_aim = aim;
        end
        else if (pick < 67)
        begin
            // Inside the deadband around the last target.
            span = $urandom_range(1, 9);
            aim  = ($urandom_range(0, 1) == 1) ? recent_aim + 16'(span) : recent_aim - 16'(span);
            push_word(REQ_SET_TARGET, aim);
        end
        else if (pick < 77)
        begin
            push_word(REQ_GO_HOME, 16'($urandom));
        end
        else if (pick < 85)
        begin
            aim = 16'($urandom);
            push_word(REQ_SET_TARGET, aim);
            recent_aim = aim;
        end
        else if (pick < 91)
        begin
            push_word(REQ_IDLE, 16'($urandom));
        end
        else
        begin
            push_word(REQ_SET_TARGET, '0);
            recent_aim = '0;
        end
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 220) : $urandom_range(3, 40);
        repeat (span) push_word(REQ_TICK, 16'($urandom));
    endtask

    // Stimulus and verdict.
    initial
    begin
        int          goal;
        logic [23:0] fast;
        logic [23:0] slow;
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        src_idles    = 1'b1;
        snk_idles    = 1'b1;
        hold_rsp     = 1'b0;
        recent_aim   = '0;
        n_ticks      = 0;
        n_targets    = 0;
        n_homes      = 0;
        n_idle       = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset settings.
        push_word(REQ_TICK, '0);
        push_word(REQ_SET_TARGET, 16'sd5);
        push_word(REQ_TICK, '1);
        push_word(REQ_IDLE, 16'hFFFF);
        push_word(REQ_SET_TARGET, '0);
        push_word(REQ_GO_HOME, '0);
        push_word(REQ_SET_TARGET, 16'h8000);
        repeat (3) push_word(REQ_TICK, '0);
        // Turn round while still accelerating.
        push_word(REQ_SET_TARGET, 16'h7FFF);
        repeat (6) push_word(REQ_TICK, '0);
        push_word(REQ_SET_TARGET, 16'sd15);
        push_word(REQ_GO_HOME, '0);
        push_word(REQ_GO_HOME, '1);
        push_word(REQ_TICK, '0);
        push_word(REQ_SET_TARGET, 16'sd20);
        push_word(REQ_TICK, '0);
        recent_aim = 16'sd20;

        // Random moves under a different register setting in each phase.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle(ph != 1, ph != 1);
            case (ph)
                0: load_settings(24'd1, FULL24, 24'd0);
                1: load_settings(FULL24, 24'd1, 24'hFFFF);
                default:
                begin
                    fast = 24'($urandom_range(1, 300));
                    slow = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, fast)) :
                           fast + 24'($urandom_range(0, 400));
                    load_settings(fast, slow, 24'($urandom_range(0, 40)));
                end
            endcase
            if (ph == 2)
            begin
                @(posedge clk);
                hold_rsp = 1'b1;
                @(negedge clk);
            end
            goal = n_ticks + n_targets + n_homes + WORDS_PER_PHASE;
            while (n_ticks + n_targets + n_homes < goal)
                run_move();
        end

        // Finish heading for a target below zero on a short ramp; an arrival there while
        // decelerating zeroes both the target and the position.
        settle(1'b0, 1'b0);
        load_settings(24'd100, 24'd1100, 24'd0);
        push_word(REQ_SET_TARGET, -16'sd60);
        repeat (FINAL_TICKS) push_word(REQ_TICK, '0);

        settle(1'b0, 1'b0);
        $display("Sent %0d ticks, %0d target words, %0d go-home words and %0d idle words.",
                 n_ticks, n_targets, n_homes, n_idle);
        $display("Checked %0d result words with %0d step pulses and %0d homing arrivals.",
                 words_checked, steps_seen, homing_arrivals);
        if (errors == 0)
            $display("stepper_trapezoid_ramp_core test passed");
        else
            $display("stepper_trapezoid_ramp_core test failed");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("stepper_trapezoid_ramp_core test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/stramp_pkg.sv
hw/rtl/stramp_stream_if.sv
hw/rtl/stramp_cfg_regs.sv
hw/rtl/stramp_ramp_engine.sv
hw/rtl/stepper_trapezoid_ramp_core.sv
tb/stepper_trapezoid_ramp_checker.sv
tb/tb_stepper_trapezoid_ramp_core.sv
